// ===== rtl/ole_pkg.sv =====
// Shared types, constants and conversion functions for the ordered list engine.
`timescale 1ns / 1ps

package ole_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [3:0] MODE_GET       = 4'd0;
    localparam logic [3:0] MODE_SET       = 4'd1;
    localparam logic [3:0] MODE_FIND      = 4'd2;
    localparam logic [3:0] MODE_INS_FRONT = 4'd3;
    localparam logic [3:0] MODE_INS_BACK  = 4'd4;
    localparam logic [3:0] MODE_INS_AT    = 4'd5;
    localparam logic [3:0] MODE_DEL_FRONT = 4'd6;
    localparam logic [3:0] MODE_DEL_BACK  = 4'd7;
    localparam logic [3:0] MODE_DEL_AT    = 4'd8;
    localparam logic [3:0] MODE_LENGTH    = 4'd9;
    localparam logic [3:0] MODE_CLEAR     = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WRITE,
        OP_INSERT,
        OP_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic [IDX_W-1:0]        at;
        logic [DATA_WIDTH-1:0]   value;
        logic [CNT_W-1:0]        count;
    } t_cell_cmd;

    typedef struct packed {
        logic [3:0]         mode;
        logic [4:0]         position;
        logic signed [31:0] item_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic [3:0]         found_position;
        logic [4:0]         element_count;
        logic [1:0]         status;
    } t_out;

    function automatic logic [DATA_WIDTH-1:0] to_stored(input logic [31:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        return e[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_stored(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] e;
        e = 64'(signed'(w));
        return e[31:0];
    endfunction

endpackage

// ===== rtl/ole_cell.sv =====
// One list cell: holds a word, takes a new value, its left or its right neighbor.
`timescale 1ns / 1ps

module ole_cell (
    input  logic                          i_clk,
    input  ole_pkg::t_cell_cmd            i_cmd,
    input  logic [ole_pkg::IDX_W-1:0]     i_idx,
    input  logic [ole_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [ole_pkg::DATA_WIDTH-1:0] i_right,
    output logic [ole_pkg::DATA_WIDTH-1:0] o_word,
    output logic                          o_match
);
    import ole_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd.op)
            OP_WRITE: begin
                if (i_idx == i_cmd.at) n_word = i_cmd.value;
            end
            OP_INSERT: begin
                if (i_idx == i_cmd.at) n_word = i_cmd.value;
                else if (i_idx > i_cmd.at) n_word = i_left;
            end
            OP_DELETE: begin
                if (i_idx >= i_cmd.at) n_word = i_right;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_cmd.value) && (CNT_W'(i_idx) < i_cmd.count);

endmodule

// ===== rtl/ole_find.sv =====
// Priority encoder that picks the lowest matching cell.
`timescale 1ns / 1ps

module ole_find (
    input  logic [ole_pkg::CAPACITY-1:0] i_match,
    output logic                         o_any,
    output logic [ole_pkg::IDX_W-1:0]    o_pos
);
    import ole_pkg::*;

    always_comb begin
        o_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (i_match[i]) o_pos = IDX_W'(i);
        end
    end

    assign o_any = |i_match;

endmodule

// ===== rtl/ordered_list_engine_core.sv =====
// Top level of the ordered list engine: command decode, cell chain and result register.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one operation (mode, position,
//   item_value). Output channel o_out_valid / i_out_ready carries one result per
//   operation (read_value, found, found_position, element_count, status).
//   Every cell of the chain updates in the same cycle as a transfer is taken,
//   shifting toward higher or lower positions for inserts and deletes, and all
//   cells compare in parallel for find.
//   Latency: the result is valid in the cycle after the input transfer.
//   Throughput: one operation per cycle while results are taken, set by the
//   single update of the cell chain and the count register per transfer.
//   The result register parts the two sides: a new input is taken whenever the
//   result register is empty or its result is being taken in the same cycle.
//   When the receiver stalls, the result holds and input stops after one item.
//   Reset clears the element count and the result valid flag; cell contents
//   are undefined until written.
`timescale 1ns / 1ps

module ordered_list_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ole_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ole_pkg::t_out o_out
);
    import ole_pkg::*;

    logic [DATA_WIDTH-1:0] w_word [CAPACITY];
    logic [CAPACITY-1:0]   w_match;
    logic                  w_any;
    logic [IDX_W-1:0]      w_fpos;

    t_cell_cmd             cmd;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_out                  r_out;
    t_out                  n_out;
    logic                  r_out_valid;
    logic                  accept;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      ins_at;
    logic [CNT_W-1:0]      del_at;
    logic [IDX_W-1:0]      rd_idx;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [31:0]           rv;
    logic [1:0]            st;
    t_cell_op              op;
    logic [IDX_W-1:0]      at;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign pos        = CNT_W'(i_in.position);

    always_comb begin
        case (i_in.mode)
            MODE_INS_FRONT: ins_at = '0;
            MODE_INS_BACK:  ins_at = r_count;
            default:        ins_at = pos;
        endcase
        case (i_in.mode)
            MODE_DEL_FRONT: del_at = '0;
            MODE_DEL_BACK:  del_at = (r_count != '0) ? r_count - CNT_W'(1) : '0;
            default:        del_at = pos;
        endcase
        rd_idx = (i_in.mode inside {MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT})
                 ? del_at[IDX_W-1:0] : pos[IDX_W-1:0];
    end

    assign rd_word = w_word[rd_idx];

    always_comb begin
        op      = OP_HOLD;
        at      = '0;
        rv      = '0;
        st      = ST_OK;
        n_count = r_count;
        case (i_in.mode)
            MODE_GET: begin
                if (pos < r_count) rv = from_stored(rd_word);
                else st = ST_BAD;
            end
            MODE_SET: begin
                if (pos < r_count) begin
                    op = OP_WRITE;
                    at = pos[IDX_W-1:0];
                end else begin
                    st = ST_BAD;
                end
            end
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    st = ST_FULL;
                end else if (ins_at > r_count) begin
                    st = ST_BAD;
                end else begin
                    op      = OP_INSERT;
                    at      = ins_at[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                if (r_count == '0 || del_at >= r_count) begin
                    st = ST_BAD;
                end else begin
                    rv      = from_stored(rd_word);
                    op      = OP_DELETE;
                    at      = del_at[IDX_W-1:0];
                    n_count = r_count - CNT_W'(1);
                end
            end
            MODE_CLEAR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        cmd.op    = accept ? op : OP_HOLD;
        cmd.at    = at;
        cmd.value = to_stored(i_in.item_value);
        cmd.count = r_count;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] left;
            logic [DATA_WIDTH-1:0] right;
            if (g == 0) begin : g_first
                assign left = cmd.value;
            end else begin : g_mid_l
                assign left = w_word[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right = w_word[g];
            end else begin : g_mid_r
                assign right = w_word[g+1];
            end
            ole_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (cmd),
                .i_idx   (IDX_W'(g)),
                .i_left  (left),
                .i_right (right),
                .o_word  (w_word[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    ole_find u_find (
        .i_match (w_match),
        .o_any   (w_any),
        .o_pos   (w_fpos)
    );

    always_comb begin
        n_out.read_value     = rv;
        n_out.found          = (i_in.mode == MODE_FIND) && w_any;
        n_out.found_position = ((i_in.mode == MODE_FIND) && w_any) ? 4'(w_fpos) : 4'd0;
        n_out.element_count  = 5'(n_count);
        n_out.status         = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== test/list_op_checker.sv =====
// Checker for the ordered list engine: predicts every result and compares it.
`timescale 1ns / 1ps

module list_op_checker
    import ole_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_list_length
);

    logic [DATA_WIDTH-1:0] list_words [CAPACITY];
    int unsigned           list_len = 0;
    t_out                  expected_results [$];
    int                    mismatch_count = 0;
    int                    pending_count = 0;

    assign o_fail_count  = mismatch_count;
    assign o_pending     = pending_count;
    assign o_list_length = list_len;

    function automatic t_out apply_list_op(t_in op);
        t_out                  r;
        logic [DATA_WIDTH-1:0] word;
        int unsigned           at;
        r    = '0;
        word = DATA_WIDTH'(op.item_value);
        case (op.mode)
            MODE_GET: begin
                if (op.position < list_len) begin
                    r.read_value = 32'(signed'(list_words[op.position[IDX_W-1:0]]));
                end else begin
                    r.status = ST_BAD;
                end
            end
            MODE_SET: begin
                if (op.position < list_len) begin
                    list_words[op.position[IDX_W-1:0]] = word;
                end else begin
                    r.status = ST_BAD;
                end
            end
            MODE_FIND: begin
                for (int i = 0; i < list_len; i++) begin
                    if (!r.found && list_words[IDX_W'(i)] == word) begin
                        r.found          = 1'b1;
                        r.found_position = 4'(i);
                    end
                end
            end
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                at = (op.mode == MODE_INS_FRONT) ? 0 :
                     (op.mode == MODE_INS_BACK) ? list_len : op.position;
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (at > list_len) begin
                    r.status = ST_BAD;
                end else begin
                    for (int i = list_len; i > at; i--) begin
                        list_words[IDX_W'(i)] = list_words[IDX_W'(i-1)];
                    end
                    list_words[IDX_W'(at)] = word;
                    list_len++;
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                at = (op.mode == MODE_DEL_FRONT) ? 0 :
                     (op.mode == MODE_DEL_BACK) ? ((list_len != 0) ? list_len - 1 : 0) :
                     op.position;
                if (list_len == 0 || at >= list_len) begin
                    r.status = ST_BAD;
                end else begin
                    r.read_value = 32'(signed'(list_words[IDX_W'(at)]));
                    for (int i = at; i + 1 < list_len; i++) begin
                        list_words[IDX_W'(i)] = list_words[IDX_W'(i+1)];
                    end
                    list_len--;
                end
            end
            MODE_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.element_count = 5'(list_len);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input t_out want, input t_out got);
        check_field("read_value", want.read_value, got.read_value);
        check_field("found", 32'(want.found), 32'(got.found));
        check_field("found_position", 32'(want.found_position), 32'(got.found_position));
        check_field("element_count", 32'(want.element_count), 32'(got.element_count));
        check_field("status", 32'(want.status), 32'(got.status));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no operation pending");
                    mismatch_count++;
                end else begin
                    check_result(expected_results.pop_front(), i_out);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_list_op(i_in));
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the ordered list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ole_pkg::*;

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         HOLD_OFF_CYCLES = 40;
    localparam logic [3:0] MODE_UNUSED_LO  = MODE_CLEAR + 4'd1;
    localparam logic [3:0] MODE_UNUSED_HI  = 4'hF;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_item;
    logic out_valid;
    logic out_ready;
    t_out out_item;

    int fail_count;
    int pending;
    int list_length;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_requests = 0;

    int send_idle_by_phase  [4] = '{0, 68, 0, 22};
    int recv_stall_by_phase [4] = '{0, 0, 68, 22};

    logic [3:0]  insert_modes [3] = '{MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT};
    logic [3:0]  delete_modes [3] = '{MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT};
    logic [3:0]  other_modes  [4] = '{MODE_GET, MODE_SET, MODE_FIND, MODE_LENGTH};
    logic [31:0] value_pool   [8] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF,
                                      32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678};

    ordered_list_engine_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    list_op_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_item),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_list_length (list_length)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int hold_off_left;
        int hold_off_seen;
        hold_off_left = 0;
        hold_off_seen = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_requests != hold_off_seen) begin
                hold_off_seen = hold_off_requests;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_list_op(input logic [3:0] mode, input logic [4:0] position,
                                input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{mode, position, value};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random_op(input int grow_pct);
        logic [3:0]  mode;
        logic [4:0]  position;
        logic [31:0] value;
        int          roll;
        roll = $urandom_range(99);
        if (roll < grow_pct) begin
            mode = insert_modes[2'($urandom_range(2))];
        end else if (roll < grow_pct + 25) begin
            mode = delete_modes[2'($urandom_range(2))];
        end else if (roll < 98) begin
            mode = other_modes[2'($urandom_range(3))];
        end else if (roll == 98) begin
            mode = MODE_CLEAR;
        end else begin
            mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end
        if ($urandom_range(9) == 0) begin
            position = 5'($urandom_range(CAPACITY));
        end else begin
            position = 5'($urandom_range(list_length));
        end
        if ($urandom_range(1) == 0) begin
            value = value_pool[3'($urandom_range(7))];
        end else begin
            value = $urandom;
        end
        send_list_op(mode, position, value);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        in_valid = 1'b0;
        in_item  = '0;
        rst_n    = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_list_op(MODE_GET, 5'd0, 32'd0);
        send_list_op(MODE_DEL_FRONT, 5'd0, 32'd0);
        send_list_op(MODE_DEL_BACK, 5'd0, 32'd0);
        send_list_op(MODE_DEL_AT, 5'd0, 32'd0);
        send_list_op(MODE_FIND, 5'd0, 32'd0);
        send_list_op(MODE_INS_AT, 5'd1, 32'd9);
        send_list_op(MODE_INS_FRONT, 5'd0, 32'h7FFF_FFFF);
        send_list_op(MODE_INS_BACK, 5'd0, 32'h8000_0000);
        send_list_op(MODE_INS_AT, 5'd1, 32'hFFFF_FFFF);
        send_list_op(MODE_INS_AT, 5'd3, 32'd0);
        send_list_op(MODE_SET, 5'd0, 32'd5);
        send_list_op(MODE_SET, 5'd16, 32'd6);
        send_list_op(MODE_GET, 5'd2, 32'd0);
        send_list_op(MODE_GET, 5'd4, 32'd0);
        send_list_op(MODE_FIND, 5'd0, 32'hFFFF_FFFF);
        send_list_op(MODE_FIND, 5'd0, 32'd12345);
        send_list_op(MODE_LENGTH, 5'd0, 32'd0);
        send_list_op(MODE_UNUSED_LO, 5'd31, 32'hFFFF_FFFF);
        send_list_op(MODE_UNUSED_HI, 5'd0, 32'd0);
        send_list_op(MODE_DEL_AT, 5'd1, 32'd0);
        send_list_op(MODE_DEL_AT, 5'd16, 32'd0);
        send_list_op(MODE_DEL_BACK, 5'd0, 32'd0);
        send_list_op(MODE_CLEAR, 5'd0, 32'd0);
        send_list_op(MODE_GET, 5'd0, 32'd0);
        wait_for_results();

        hold_off_requests++;
        repeat (12) send_random_op(60);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_idle_by_phase[2'(phase)];
            recv_stall_pct = recv_stall_by_phase[2'(phase)];
            repeat (90) send_random_op(60);
            repeat (90) send_random_op(15);
            wait_for_results();
        end

        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
